@@ hw/rtl/gf16prg_pkg.sv @@
// shared types, constants and field arithmetic for the gf16 polynomial generator
package gf16prg_pkg;

	// number of coefficient slots and derived widths
	localparam int unsigned MaxCoeffs = 16;
	localparam int unsigned IdxW      = $clog2(MaxCoeffs);
	localparam int unsigned DegW      = 5;
	localparam int unsigned CoefW     = 16;
	localparam int unsigned WordW     = 64;
	localparam int unsigned NumWords  = 4;
	localparam int unsigned CfgIdxW   = 3;

	// low byte of the aes reduction polynomial and the y^2 + y + 32 constant
	localparam logic [7:0] AesPolyLow = 8'h1B;
	localparam logic [7:0] ReduceK    = 8'h20;

	localparam logic [DegW-1:0] DegReset = DegW'(MaxCoeffs);

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEGREE = 3'd0,
		CFG_COEF_A = 3'd1,
		CFG_COEF_B = 3'd2,
		CFG_COEF_C = 3'd3,
		CFG_COEF_D = 3'd4
	} cfg_reg_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT_LOW,
		ST_EMIT_HIGH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic step;
		logic emit_low;
		logic emit_high;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pending;
		logic deg_zero;
		logic last_step;
		logic out_free;
	} status_t;

	// gf(256) multiply, aes polynomial
	function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] aa;
		p  = '0;
		aa = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p = p ^ aa;
			aa = {aa[6:0], 1'b0} ^ (aa[7] ? AesPolyLow : 8'h00);
		end
		return p;
	endfunction

	// gf(2^16) multiply, element packed as {hi, lo}
	function automatic logic [15:0] gf16_mul(input logic [15:0] a, input logic [15:0] b);
		logic [7:0] hh;
		logic [7:0] c0;
		logic [7:0] c1;
		hh = gf256_mul(a[15:8], b[15:8]);
		c0 = gf256_mul(a[7:0], b[7:0]) ^ gf256_mul(ReduceK, hh);
		c1 = gf256_mul(a[15:8], b[7:0]) ^ gf256_mul(a[7:0], b[15:8]) ^ hh;
		return {c1, c0};
	endfunction

endpackage

@@ hw/rtl/gf16prg_draw_if.sv @@
// request channel carrying one draw item
interface gf16prg_draw_if;
	logic valid;
	logic ready;
	logic draw;

	modport source (output valid, output draw, input ready);
	modport sink (input valid, input draw, output ready);
endinterface

@@ hw/rtl/gf16prg_byte_if.sv @@
// result channel carrying one random byte item
interface gf16prg_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] random_byte;

	modport source (output valid, output random_byte, input ready);
	modport sink (input valid, input random_byte, output ready);
endinterface

@@ hw/rtl/gf16prg_ctrl.sv @@
// controller state machine for the gf16 polynomial generator
module gf16prg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_draw,
	output logic                 req_ready,
	input  gf16prg_pkg::status_t status,
	output gf16prg_pkg::cmd_t    cmd
);

	gf16prg_pkg::state_t state_q;
	gf16prg_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gf16prg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			gf16prg_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && req_draw) begin
					if (status.pending) begin
						state_d = gf16prg_pkg::ST_EMIT_HIGH;
					end else begin
						cmd.clear = 1'b1;
						state_d   = status.deg_zero ? gf16prg_pkg::ST_EMIT_LOW
						                            : gf16prg_pkg::ST_EVAL;
					end
				end
			end
			gf16prg_pkg::ST_EVAL: begin
				cmd.step = 1'b1;
				if (status.last_step) state_d = gf16prg_pkg::ST_EMIT_LOW;
			end
			gf16prg_pkg::ST_EMIT_LOW: begin
				if (status.out_free) begin
					cmd.emit_low = 1'b1;
					state_d      = gf16prg_pkg::ST_IDLE;
				end
			end
			gf16prg_pkg::ST_EMIT_HIGH: begin
				if (status.out_free) begin
					cmd.emit_high = 1'b1;
					state_d       = gf16prg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gf16prg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/gf16prg_dp.sv @@
// datapath: config registers, horner accumulator, counter and output register
module gf16prg_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gf16prg_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [gf16prg_pkg::WordW-1:0]       cfg_data,
	input  gf16prg_pkg::cmd_t                   cmd,
	output gf16prg_pkg::status_t                status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [7:0]                          out_byte
);

	logic [gf16prg_pkg::DegW-1:0]  degree_q;
	logic [gf16prg_pkg::WordW-1:0] coef_q [gf16prg_pkg::NumWords];
	logic [15:0]                   counter_q;
	logic                          pending_q;
	logic [7:0]                    held_q;
	logic [15:0]                   acc_q;
	logic [gf16prg_pkg::IdxW-1:0]  idx_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;

	logic [gf16prg_pkg::IdxW-1:0]  idx_start;
	logic [gf16prg_pkg::WordW-1:0] coef_word;
	logic [gf16prg_pkg::CoefW-1:0] coef_val;
	logic [15:0]                   horner_next;
	logic                          out_free;

	// top coefficient index, degree saturated at the slot count
	assign idx_start = (degree_q >= gf16prg_pkg::DegW'(gf16prg_pkg::MaxCoeffs))
		? gf16prg_pkg::IdxW'(gf16prg_pkg::MaxCoeffs - 1)
		: gf16prg_pkg::IdxW'(degree_q - 1'b1);

	// coefficient select and one horner step
	assign coef_word   = coef_q[idx_q[gf16prg_pkg::IdxW-1:2]];
	assign coef_val    = coef_word[{idx_q[1:0], 4'b0000} +: gf16prg_pkg::CoefW];
	assign horner_next = gf16prg_pkg::gf16_mul(acc_q, counter_q) ^ coef_val;

	assign out_free = !out_valid_q || out_ready;

	assign status.pending   = pending_q;
	assign status.deg_zero  = (degree_q == '0);
	assign status.last_step = (idx_q == '0);
	assign status.out_free  = out_free;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= gf16prg_pkg::DegReset;
			for (int i = 0; i < gf16prg_pkg::NumWords; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gf16prg_pkg::CFG_DEGREE: degree_q  <= cfg_data[gf16prg_pkg::DegW-1:0];
				gf16prg_pkg::CFG_COEF_A: coef_q[0] <= cfg_data;
				gf16prg_pkg::CFG_COEF_B: coef_q[1] <= cfg_data;
				gf16prg_pkg::CFG_COEF_C: coef_q[2] <= cfg_data;
				gf16prg_pkg::CFG_COEF_D: coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// generator state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q   <= '0;
			pending_q   <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_low || cmd.emit_high) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.emit_low) begin
				counter_q   <= counter_q + 16'd1;
				pending_q   <= 1'b1;
				held_q      <= acc_q[15:8];
			end
			if (cmd.emit_high) begin
				pending_q   <= 1'b0;
			end
		end
	end

	// accumulator, step index and output byte
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			acc_q <= '0;
			idx_q <= idx_start;
		end else if (cmd.step) begin
			acc_q <= horner_next;
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.emit_low) out_byte_q <= acc_q[7:0];
		else if (cmd.emit_high) out_byte_q <= held_q;
	end

endmodule

@@ hw/rtl/gf16_polynomial_prg.sv @@
// top level of the gf16 polynomial pseudo-random byte generator
//
// request carries draw items; an item with draw low is taken and yields nothing.
// result carries one random_byte item for each draw item with draw high.
// the block works on one item at a time. a draw that finds a held high byte
// returns it through the emit-high state and the output register. otherwise
// the polynomial is evaluated at the 16-bit counter with one gf(2^16) multiply
// per cycle by the shared multiplier, one horner step per coefficient in use
// (the degree, saturated at 16); emit-low then loads the low byte into the
// output register, holds the high byte for the next draw and returns to idle.
// reset: degree 16, all coefficients zero, counter zero, no held byte.
// a finished result sits in an output register; the next draw is accepted while
// it waits, and the block holds in its emit step when the receiver stalls.
// configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module gf16_polynomial_prg (
	input  logic                               clk,
	input  logic                               arst_n,
	gf16prg_draw_if.sink                       request,
	gf16prg_byte_if.source                     result,
	input  logic                               cfg_we,
	input  logic [gf16prg_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [gf16prg_pkg::WordW-1:0]      cfg_data
);

	gf16prg_pkg::cmd_t    cmd;
	gf16prg_pkg::status_t status;
	logic                 req_ready;
	logic                 out_valid;
	logic [7:0]           out_byte;

	// controller
	gf16prg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_draw  (request.draw),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	gf16prg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (result.ready),
		.out_valid (out_valid),
		.out_byte  (out_byte)
	);

	// channel hookup
	assign request.ready      = req_ready;
	assign result.valid       = out_valid;
	assign result.random_byte = out_byte;

endmodule
